// ===== src/radiogatun32_hash_defines.svh =====
// assertion macros used by the radiogatun32 round core
`ifndef RADIOGATUN32_HASH_DEFINES_SVH
`define RADIOGATUN32_HASH_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rg32 same-cycle check failed");

// next-cycle implication, checked outside reset
`define RG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rg32 next-cycle check failed");

`endif

// ===== src/rg32_pkg.sv =====
// types, constants and round function of the radiogatun32 hash
`default_nettype none

package rg32_pkg;

  localparam int MillLen     = 19;
  localparam int BeltRow     = 13;
  localparam int BeltLen     = 39;
  localparam int BlankRounds = 17;
  localparam int OutRounds   = 4;
  localparam int CmdDepth    = 4;
  localparam int CmdPtrW     = $clog2(CmdDepth);

  localparam logic [1:0] LastWordInBlock = 2'd2;

  typedef logic [MillLen-1:0][31:0] mill_t;
  typedef logic [BeltLen-1:0][31:0] belt_t;

  typedef struct packed {
    mill_t mill;
    belt_t belt;
  } rg_state_t;

  // one word for the core: a block word, or the padded final word
  typedef struct packed {
    logic        is_end;
    logic [1:0]  k;
    logic [31:0] word;
  } cmd_t;

  function automatic rg_state_t rg_inject(rg_state_t s, logic [1:0] k, logic [31:0] w);
    rg_state_t o;
    o = s;
    case (k)
      2'd0: begin
        o.belt[0]       = s.belt[0] ^ w;
        o.mill[16]      = s.mill[16] ^ w;
      end
      2'd1: begin
        o.belt[BeltRow] = s.belt[BeltRow] ^ w;
        o.mill[17]      = s.mill[17] ^ w;
      end
      default: begin
        o.belt[2*BeltRow] = s.belt[2*BeltRow] ^ w;
        o.mill[18]        = s.mill[18] ^ w;
      end
    endcase
    return o;
  endfunction

  // one belt-mill round
  function automatic rg_state_t rg_round(rg_state_t s);
    mill_t       m;
    belt_t       b;
    belt_t       bo;
    mill_t       g;
    mill_t       mo;
    logic [31:0] x;
    logic [63:0] xx;
    logic [31:0] last;
    rg_state_t   o;
    m = s.mill;
    b = s.belt;
    // mill to belt feedforward
    for (int i = 0; i < 12; i++) begin
      b[i + (i % 3) * BeltRow] = b[i + (i % 3) * BeltRow] ^ m[i + 1];
    end
    // gamma and pi, rotation amounts are triangular numbers mod 32
    for (int i = 0; i < MillLen; i++) begin
      x = m[(i * 7) % MillLen] ^
          (m[(i * 7 + 1) % MillLen] | ~m[(i * 7 + 2) % MillLen]);
      xx = {x, x} >> ((i * (i + 1) / 2) % 32);
      g[i] = xx[31:0];
    end
    // theta
    for (int i = 0; i < MillLen; i++) begin
      mo[i] = g[i] ^ g[(i + 1) % MillLen] ^ g[(i + 4) % MillLen];
    end
    mo[0] = mo[0] ^ 32'd1;
    // belt rotation and belt to mill
    for (int row = 0; row < 3; row++) begin
      last = b[row * BeltRow + BeltRow - 1];
      for (int i = 1; i < BeltRow; i++) begin
        bo[row * BeltRow + i] = b[row * BeltRow + i - 1];
      end
      bo[row * BeltRow] = last;
      mo[13 + row] = mo[13 + row] ^ last;
    end
    o.mill = mo;
    o.belt = bo;
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== src/rg32_front.sv =====
// byte packer: turns message bytes into block words and end commands
`default_nettype none

module rg32_front
  import rg32_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end,
  output      logic       push,
  output      cmd_t       push_cmd,
  input  wire logic       full
);

  logic [31:0] word_accum;
  logic [1:0]  byte_pos;
  logic [1:0]  word_in_block;
  logic        accept;
  logic [4:0]  shamt;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign shamt    = {byte_pos, 3'b000};
  assign push     = accept && (in_end || (byte_pos == 2'd3));

  always_comb begin
    push_cmd.is_end = in_end;
    push_cmd.k      = word_in_block;
    if (in_end) begin
      push_cmd.word = word_accum | (32'd1 << shamt);
    end else begin
      push_cmd.word = word_accum | ({24'd0, in_byte} << shamt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_accum    <= '0;
      byte_pos      <= '0;
      word_in_block <= '0;
    end else if (accept) begin
      if (in_end) begin
        word_accum    <= '0;
        byte_pos      <= '0;
        word_in_block <= '0;
      end else if (byte_pos == 2'd3) begin
        word_accum    <= '0;
        byte_pos      <= '0;
        word_in_block <= (word_in_block == LastWordInBlock) ? 2'd0 : word_in_block + 2'd1;
      end else begin
        word_accum <= push_cmd.word;
        byte_pos   <= byte_pos + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rg32_cmd_fifo.sv =====
// short command queue between the byte packer and the round core
`default_nettype none

module rg32_cmd_fifo
  import rg32_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output      logic full,
  input  wire logic pop,
  output      cmd_t pop_cmd,
  output      logic empty
);

  cmd_t               mem [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr;
  logic [CmdPtrW-1:0] rd_ptr;
  logic [CmdPtrW:0]   count;

  assign full    = (count == CmdPtrW'(0) + (CmdPtrW+1)'(CmdDepth));
  assign empty   = (count == '0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/rg32_core.sv =====
// round core: holds mill and belt, injects words, finalizes and emits the digest
`default_nettype none

`include "radiogatun32_hash_defines.svh"

module rg32_core
  import rg32_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_empty,
  input  wire cmd_t        cmd,
  output      logic        cmd_pop,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] out_word,
  output      logic        out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLANK,
    S_OUT_ROUND,
    S_EMIT1,
    S_EMIT2
  } core_state_t;

  core_state_t state;
  rg_state_t   st;
  rg_state_t   injected;
  rg_state_t   rounded;
  logic [4:0]  blank_cnt;
  logic [1:0]  out_cnt;
  logic        out_load;
  logic        emit_load;

  assign cmd_pop   = (state == S_IDLE) && !cmd_empty;
  assign out_load  = !out_valid || out_ready;
  assign emit_load = ((state == S_EMIT1) || (state == S_EMIT2)) && out_load;
  assign injected  = rg_inject(st, cmd.k, cmd.word);
  assign rounded   = rg_round((state == S_IDLE) ? injected : st);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      st        <= '0;
      blank_cnt <= '0;
      out_cnt   <= '0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
      out_word  <= '0;
    end else begin
      // a new item is loaded, or the held one drains on acceptance
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            if (cmd.is_end) begin
              st        <= injected;
              blank_cnt <= '0;
              state     <= S_BLANK;
            end else if (cmd.k == LastWordInBlock) begin
              st <= rounded;
            end else begin
              st <= injected;
            end
          end
        end
        S_BLANK: begin
          st        <= rounded;
          blank_cnt <= blank_cnt + 5'd1;
          if (blank_cnt == 5'(BlankRounds - 1)) begin
            out_cnt <= '0;
            state   <= S_OUT_ROUND;
          end
        end
        S_OUT_ROUND: begin
          st    <= rounded;
          state <= S_EMIT1;
        end
        S_EMIT1: begin
          if (out_load) begin
            out_word  <= st.mill[1];
            out_last  <= 1'b0;
            state     <= S_EMIT2;
          end
        end
        S_EMIT2: begin
          if (out_load) begin
            out_word  <= st.mill[2];
            out_last  <= (out_cnt == 2'(OutRounds - 1));
            if (out_cnt == 2'(OutRounds - 1)) begin
              // digest done, state back to zero
              st    <= '0;
              state <= S_IDLE;
            end else begin
              out_cnt <= out_cnt + 2'd1;
              state   <= S_OUT_ROUND;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RG_ASSERT_NXT(a_clear_after_digest, (state == S_EMIT2) && out_load && (out_cnt == 2'(OutRounds - 1)), (state == S_IDLE) && (st == '0) && out_valid && out_last)
  `RG_ASSERT_IMP(a_blank_bound, state == S_BLANK, blank_cnt <= 5'(BlankRounds - 1))
  `RG_ASSERT_NXT(a_end_starts_final, cmd_pop && cmd.is_end, (state == S_BLANK) && (blank_cnt == '0))

endmodule

`default_nettype wire

// ===== src/radiogatun32_hash.sv =====
// RadioGatun[32] hash: byte stream in, eight 32-bit digest words out
//
// Input channel s_axis: one message byte per item in tdata; an item with
// tlast high ends the message (its tdata is ignored) and starts finalization.
// Output channel m_axis: eight digest words per message, tlast on the eighth.
// Bytes are packed into words and handed to the round core through a
// four-entry command queue; s_axis_tready is low only while that queue is full.
// One data item is taken per cycle while the queue is not full; every third
// word the core injects and runs one round at once, so byte input is never
// held back by block processing. An end item costs one inject plus 21 rounds
// in the core: the blank rounds back to back, then the output rounds; after
// each output round, mill words 1 and 2 go out as digest words, each held
// until taken. A stalled receiver holds the core in its emit step and the queue
// fills, after which s_axis_tready drops. The output word is registered.
// Synchronous reset clears mill, belt, packer and queue; no clearing pass.
`default_nettype none

module radiogatun32_hash
  import rg32_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  wire logic        s_axis_tlast,   // msg_end
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output      logic        m_axis_tlast    // digest_last
);

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  cmd_t pop_cmd;
  logic empty;

  rg32_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_end   (s_axis_tlast),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  rg32_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  rg32_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (empty),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== test/radiogatun32_hash_test.sv =====
// self-checking testbench for the radiogatun32 byte-stream hash
module radiogatun32_hash_test;
  import rg32_pkg::MillLen;
  import rg32_pkg::BeltRow;
  import rg32_pkg::BeltLen;
  import rg32_pkg::BlankRounds;
  import rg32_pkg::OutRounds;

  localparam int StallLimit = 1000;
  localparam int DrainCycles = 40;
  localparam int RandomItems = 330;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'd0;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  // hash state mirrored by the predictor
  logic [31:0] mill_st [MillLen];
  logic [31:0] belt_st [BeltLen];
  logic [31:0] word_acc;
  int unsigned byte_cnt;
  int unsigned words_in_block;

  digest_item_t pending_digest[$];
  int unsigned  fault_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  items_sent = 0;
  logic         no_idle = 1'b0;

  always #6 clk = ~clk;

  radiogatun32_hash u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic void clear_hash_state();
    foreach (mill_st[i]) mill_st[i] = 32'd0;
    foreach (belt_st[i]) belt_st[i] = 32'd0;
    word_acc = 32'd0;
    byte_cnt = 0;
    words_in_block = 0;
  endfunction

  // one belt-mill round
  function automatic void mix_round();
    logic [31:0] g [MillLen];
    logic [31:0] x;
    logic [31:0] spill;
    int unsigned y;
    int unsigned rot;
    for (int i = 0; i < 12; i++) begin
      belt_st[i + (i % 3) * BeltRow] ^= mill_st[i + 1];
    end
    rot = 0;
    for (int i = 0; i < MillLen; i++) begin
      y = (i * 7) % MillLen;
      x = mill_st[y] ^ (mill_st[(y + 1) % MillLen] | ~mill_st[(y + 2) % MillLen]);
      rot = (rot + i) % 32;
      // a shift by 32 yields zero, so rot of zero leaves x unchanged
      g[i] = (x >> rot) | (x << (32 - rot));
    end
    for (int i = 0; i < MillLen; i++) begin
      mill_st[i] = g[i] ^ g[(i + 1) % MillLen] ^ g[(i + 4) % MillLen];
    end
    mill_st[0] ^= 32'd1;
    for (int row = 0; row < 3; row++) begin
      spill = belt_st[row * BeltRow + BeltRow - 1];
      for (int i = BeltRow - 1; i > 0; i--) begin
        belt_st[row * BeltRow + i] = belt_st[row * BeltRow + i - 1];
      end
      belt_st[row * BeltRow] = spill;
      mill_st[13 + row] ^= spill;
    end
  endfunction

  function automatic void inject_word(logic [31:0] w);
    int unsigned k;
    k = words_in_block % 3;
    belt_st[k * BeltRow] ^= w;
    mill_st[16 + k] ^= w;
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    word_acc |= {24'd0, b} << (8 * byte_cnt);
    byte_cnt = (byte_cnt + 1) % 4;
    if (byte_cnt == 0) begin
      inject_word(word_acc);
      word_acc = 32'd0;
      words_in_block++;
      if (words_in_block >= 3) begin
        words_in_block = 0;
        mix_round();
      end
    end
  endfunction

  // pad, run the blank rounds, then queue the eight digest words
  function automatic void finish_digest();
    digest_item_t d;
    inject_word(word_acc | (32'd1 << (8 * byte_cnt)));
    for (int i = 0; i < BlankRounds; i++) mix_round();
    for (int i = 0; i < OutRounds; i++) begin
      mix_round();
      d.word = mill_st[1];
      d.last = 1'b0;
      pending_digest.push_back(d);
      d.word = mill_st[2];
      d.last = (i == OutRounds - 1);
      pending_digest.push_back(d);
    end
    clear_hash_state();
  endfunction

  function automatic void check_digest_word(logic [31:0] word, logic last);
    digest_item_t d;
    if (pending_digest.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("unexpected digest item: word %h last %b", word, last);
    end else begin
      d = pending_digest.pop_front();
      if (word !== d.word || last !== d.last) begin
        fault_count++;
        if (fault_count <= 10)
          $display("digest mismatch: expected word %h last %b, got word %h last %b",
                   d.word, d.last, word, last);
      end
    end
  endfunction

  // called at a rising edge; returns at the edge where the item is accepted
  task automatic send_item(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= fin;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    items_sent++;
    if (fin) finish_digest();
    else absorb_byte(b);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_message(input int unsigned len);
    for (int i = 0; i < len; i++) send_item(pick_byte(), 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_empty_message();
    // payload of an end item is ignored
    send_item(8'hA5, 1'b1);
  endtask

  task automatic test_zero_bytes();
    repeat (3) send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_byte_extremes();
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'hFE, 1'b0);
    send_item(8'hFF, 1'b1);
  endtask

  // message that fills exactly one block, so padding starts a fresh block
  task automatic test_block_boundary();
    send_message(12);
  endtask

  task automatic test_random_messages();
    int unsigned len;
    int unsigned start;
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: len = 0;
        1, 2: len = 12 * $urandom_range(1, 4);
        3: len = 12 * $urandom_range(1, 3) + 1;
        4: len = 12 * $urandom_range(1, 3) - 1;
        5: len = $urandom_range(40, 90);
        default: len = $urandom_range(1, 30);
      endcase
      send_message(len);
    end
    no_idle = 1'b0;
  endtask

  // receiver: random stalls, result checked while stable before its accepting edge
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      int unsigned hold;
      hold = no_idle ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        m_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(negedge clk); while (!m_axis_tvalid);
      check_digest_word(m_axis_tdata, m_axis_tlast);
      @(posedge clk);
    end
  end

  // watchdog on cycles where neither side moves an item
  always @(negedge clk) begin
    if (rst || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    clear_hash_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_message();
    test_zero_bytes();
    test_byte_extremes();
    test_block_boundary();
    test_random_messages();
    s_valid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/rg32_pkg.sv
src/rg32_front.sv
src/rg32_cmd_fifo.sv
src/rg32_core.sv
src/radiogatun32_hash.sv
test/radiogatun32_hash_test.sv
